// ----- hdl/iar_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII radix converter.
`default_nettype none

package iar_pkg;

	localparam int VALUE_BITS       = 32;
	localparam int FIXED_HEX_DIGITS = 8;
	// digit register holds every octal digit of a word and every fixed-hex digit
	localparam int DIGITS           = ((VALUE_BITS + 2) / 3 > FIXED_HEX_DIGITS) ?
		(VALUE_BITS + 2) / 3 : FIXED_HEX_DIGITS;
	localparam int DIGIT_W          = 4;
	localparam int CHAR_W           = 7;
	localparam int CNT_W            = $clog2(DIGITS + 1);
	localparam int BIT_W            = $clog2(VALUE_BITS);

	localparam logic [CHAR_W-1:0] MINUS_CODE = CHAR_W'(45);

	typedef enum logic [1:0] {
		CMD_DEC       = 2'd0,
		CMD_OCT       = 2'd1,
		CMD_HEX       = 2'd2,
		CMD_HEX_FIXED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CONV = 2'd1,
		S_EMIT = 2'd2
	} state_t;

	typedef enum logic [2:0] {
		DOP_HOLD     = 3'd0,
		DOP_CLEAR    = 3'd1,
		DOP_LOAD_OCT = 3'd2,
		DOP_LOAD_HEX = 3'd3,
		DOP_LOAD_FIX = 3'd4,
		DOP_DABBLE   = 3'd5,
		DOP_SHIFT    = 3'd6
	} dig_op_t;

	typedef struct packed {
		dig_op_t               op;
		logic [VALUE_BITS-1:0] data;
		logic                  bit_in;
	} dig_ctrl_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		cmd_t                  command;
	} word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} sym_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < DIGIT_W'(10))
			return CHAR_W'(48) + dx;
		else
			return CHAR_W'(55) + dx;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/integer_to_ascii_radix_core.sv -----
// Top level: integer word to ASCII digit stream in decimal, octal or hex.
`default_nettype none

// Converts one 32-bit word per transaction into a stream of ASCII characters,
// most significant first, with last set on the final one. Commands: decimal,
// octal, variable-length hex (no leading zeros, zero prints "0", negative
// words get a leading '-' and their unsigned magnitude), and fixed eight-digit
// hex of the raw bits. Octal and hex load the 11-entry digit register directly;
// decimal runs a double-dabble conversion, one value bit per cycle, over all
// 32 value bits. Emission then walks the digit register one digit per cycle
// while the output is not stalled, dropping leading zeros: all 11 digits for
// variable modes (plus the sign), 8 for fixed hex. The next word is taken as
// soon as the last character sits in the output register.

module integer_to_ascii_radix_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            word_valid,
	output logic                 word_stall,
	input  wire iar_pkg::word_t  word,
	output logic                 sym_valid,
	input  wire logic            sym_stall,
	output iar_pkg::sym_t        sym
);

	iar_pkg::state_t state_q, state_d;

	logic [iar_pkg::VALUE_BITS-1:0] mag_q;
	logic [iar_pkg::BIT_W-1:0]      bit_q;
	logic [iar_pkg::CNT_W-1:0]      cnt_q;
	logic                           started_q;
	logic                           sign_q;
	logic                           out_valid_q;
	iar_pkg::sym_t                  out_q;

	iar_pkg::dig_ctrl_t             dctrl;
	logic [iar_pkg::DIGIT_W-1:0]    top_digit;

	logic [iar_pkg::VALUE_BITS-1:0] raw;
	logic [iar_pkg::VALUE_BITS-1:0] mag;
	logic                           neg;
	logic                           out_free;
	logic                           accept;

	logic                           start;
	logic                           conv_step;
	logic                           cnt_dec;
	logic                           sign_clr;
	logic                           started_set;
	logic                           out_load;
	iar_pkg::sym_t                  out_d;

	assign raw      = word.value;
	assign neg      = raw[iar_pkg::VALUE_BITS-1] && (word.command != iar_pkg::CMD_HEX_FIXED);
	assign mag      = neg ? (~raw + 1'b1) : raw;
	assign out_free = !out_valid_q || !sym_stall;
	assign word_stall = (state_q != iar_pkg::S_IDLE);
	assign accept   = word_valid && !word_stall;

	iar_digit_reg u_digits (
		.clk       (clk),
		.ctrl      (dctrl),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= iar_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		dctrl.op     = iar_pkg::DOP_HOLD;
		dctrl.data   = mag;
		dctrl.bit_in = mag_q[iar_pkg::VALUE_BITS-1];
		start        = 1'b0;
		conv_step    = 1'b0;
		cnt_dec      = 1'b0;
		sign_clr     = 1'b0;
		started_set  = 1'b0;
		out_load     = 1'b0;
		out_d.char_code = iar_pkg::glyph(top_digit);
		out_d.last      = (cnt_q == iar_pkg::CNT_W'(1));
		unique case (state_q)
			iar_pkg::S_IDLE: begin
				if (accept) begin
					start = 1'b1;
					unique case (word.command)
						iar_pkg::CMD_DEC: begin
							dctrl.op = iar_pkg::DOP_CLEAR;
							state_d  = iar_pkg::S_CONV;
						end
						iar_pkg::CMD_OCT: begin
							dctrl.op = iar_pkg::DOP_LOAD_OCT;
							state_d  = iar_pkg::S_EMIT;
						end
						iar_pkg::CMD_HEX: begin
							dctrl.op = iar_pkg::DOP_LOAD_HEX;
							state_d  = iar_pkg::S_EMIT;
						end
						iar_pkg::CMD_HEX_FIXED: begin
							dctrl.op   = iar_pkg::DOP_LOAD_FIX;
							dctrl.data = raw;
							state_d    = iar_pkg::S_EMIT;
						end
						default: state_d = iar_pkg::S_IDLE;
					endcase
				end
			end
			iar_pkg::S_CONV: begin
				dctrl.op  = iar_pkg::DOP_DABBLE;
				conv_step = 1'b1;
				if (bit_q == iar_pkg::BIT_W'(iar_pkg::VALUE_BITS - 1))
					state_d = iar_pkg::S_EMIT;
			end
			iar_pkg::S_EMIT: begin
				if (sign_q) begin
					if (out_free) begin
						out_load        = 1'b1;
						out_d.char_code = iar_pkg::MINUS_CODE;
						out_d.last      = 1'b0;
						sign_clr        = 1'b1;
					end
				end else if (!started_q && top_digit == '0 && cnt_q > iar_pkg::CNT_W'(1)) begin
					// leading zero: drop it without producing a character
					dctrl.op = iar_pkg::DOP_SHIFT;
					cnt_dec  = 1'b1;
				end else if (out_free) begin
					out_load    = 1'b1;
					dctrl.op    = iar_pkg::DOP_SHIFT;
					cnt_dec     = 1'b1;
					started_set = 1'b1;
					if (cnt_q == iar_pkg::CNT_W'(1))
						state_d = iar_pkg::S_IDLE;
				end
			end
			default: state_d = iar_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q       <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				bit_q     <= '0;
				cnt_q     <= (word.command == iar_pkg::CMD_HEX_FIXED) ?
					iar_pkg::CNT_W'(iar_pkg::FIXED_HEX_DIGITS) :
					iar_pkg::CNT_W'(iar_pkg::DIGITS);
				started_q <= (word.command == iar_pkg::CMD_HEX_FIXED);
				sign_q    <= neg;
			end else begin
				if (conv_step)
					bit_q <= bit_q + 1'b1;
				if (cnt_dec)
					cnt_q <= cnt_q - 1'b1;
				if (started_set)
					started_q <= 1'b1;
				if (sign_clr)
					sign_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!sym_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			mag_q <= mag;
		else if (conv_step)
			mag_q <= {mag_q[iar_pkg::VALUE_BITS-2:0], 1'b0};
		if (out_load)
			out_q <= out_d;
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

	a_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(state_q == iar_pkg::S_EMIT))
		else $error("output loaded outside emit state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= iar_pkg::CNT_W'(iar_pkg::DIGITS))
		else $error("digit count out of range");

	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iar_pkg::S_EMIT) |-> (cnt_q != '0))
		else $error("emit state with no digits left");

	a_sign_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sign_q |-> (state_q != iar_pkg::S_IDLE))
		else $error("sign pending while idle");

	a_conv_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iar_pkg::S_CONV) |-> (cnt_q == iar_pkg::CNT_W'(iar_pkg::DIGITS) && !started_q))
		else $error("decimal conversion with bad emit setup");

endmodule

`default_nettype wire

// ----- hdl/iar_digit_reg.sv -----
// Digit shift register: radix loads, double-dabble BCD steps and MSD-first shift out.
`default_nettype none

module iar_digit_reg (
	input  wire logic                            clk,
	input  wire iar_pkg::dig_ctrl_t              ctrl,
	output logic [iar_pkg::DIGIT_W-1:0]          top_digit
);

	localparam int OCT_W = 3 * iar_pkg::DIGITS;
	localparam int HEX_W = iar_pkg::DIGIT_W * iar_pkg::DIGITS;
	localparam int FIX_LO = iar_pkg::DIGITS - iar_pkg::FIXED_HEX_DIGITS;

	logic [iar_pkg::DIGITS-1:0][iar_pkg::DIGIT_W-1:0] dig_q;
	logic [iar_pkg::DIGITS-1:0][iar_pkg::DIGIT_W-1:0] dig_d;
	logic [iar_pkg::DIGITS-1:0][iar_pkg::DIGIT_W-1:0] adj;
	logic [OCT_W-1:0] oct_ext;
	logic [HEX_W-1:0] hex_ext;

	assign oct_ext = OCT_W'(ctrl.data);
	assign hex_ext = HEX_W'(ctrl.data);

	// add-3 correction per BCD digit, all digits in parallel
	always_comb begin
		for (int k = 0; k < iar_pkg::DIGITS; k++) begin
			if (dig_q[k] >= iar_pkg::DIGIT_W'(5))
				adj[k] = dig_q[k] + iar_pkg::DIGIT_W'(3);
			else
				adj[k] = dig_q[k];
		end
	end

	always_comb begin
		dig_d = dig_q;
		unique case (ctrl.op)
			iar_pkg::DOP_HOLD: dig_d = dig_q;
			iar_pkg::DOP_CLEAR: dig_d = '0;
			iar_pkg::DOP_LOAD_OCT: begin
				for (int k = 0; k < iar_pkg::DIGITS; k++)
					dig_d[k] = {1'b0, oct_ext[3*k +: 3]};
			end
			iar_pkg::DOP_LOAD_HEX: begin
				for (int k = 0; k < iar_pkg::DIGITS; k++)
					dig_d[k] = hex_ext[iar_pkg::DIGIT_W*k +: iar_pkg::DIGIT_W];
			end
			iar_pkg::DOP_LOAD_FIX: begin
				for (int k = 0; k < iar_pkg::DIGITS; k++) begin
					if (k >= FIX_LO)
						dig_d[k] = hex_ext[iar_pkg::DIGIT_W*(k-FIX_LO) +: iar_pkg::DIGIT_W];
					else
						dig_d[k] = '0;
				end
			end
			iar_pkg::DOP_DABBLE: begin
				dig_d[0] = {adj[0][iar_pkg::DIGIT_W-2:0], ctrl.bit_in};
				for (int k = 1; k < iar_pkg::DIGITS; k++)
					dig_d[k] = {adj[k][iar_pkg::DIGIT_W-2:0],
						adj[k-1][iar_pkg::DIGIT_W-1]};
			end
			iar_pkg::DOP_SHIFT: begin
				dig_d[0] = '0;
				for (int k = 1; k < iar_pkg::DIGITS; k++)
					dig_d[k] = dig_q[k-1];
			end
			default: dig_d = dig_q;
		endcase
	end

	always_ff @(posedge clk) begin
		dig_q <= dig_d;
	end

	assign top_digit = dig_q[iar_pkg::DIGITS-1];

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the integer to ASCII radix converter.
module testbench;
	import iar_pkg::*;

	typedef struct {
		word_t w;
		bit    drain;
	} pending_t;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  word_valid = 1'b0;
	word_t word       = '0;
	logic  sym_stall  = 1'b0;
	logic  word_stall;
	logic  sym_valid;
	sym_t  sym;

	pending_t pending_words[$];
	sym_t     expected_chars[$];
	string    digit_chars     = "0123456789ABCDEF";
	int       chars_predicted = 0;
	int       chars_seen      = 0;
	int       error_count     = 0;
	int       cycle_cnt       = 0;
	int       hold_left       = 0;
	logic     calm;
	logic     took;

	integer_to_ascii_radix_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym        (sym)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// both sides run without idling inside this window
	assign calm = (cycle_cnt >= 6000) && (cycle_cnt < 9000);

	function automatic void push_char(input logic [7:0] code, input bit is_last);
		sym_t s;
		s.char_code = code[CHAR_W-1:0];
		s.last      = is_last;
		expected_chars.push_back(s);
	endfunction

	// Expected character stream of one word; returns the number of characters.
	function automatic int predict_chars(input word_t w);
		logic [63:0]        raw;
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]         digs[DIGITS];
		int                 cnt;
		int                 radix;
		int                 n;
		n   = 0;
		raw = 64'(w.value);
		if (w.command == CMD_HEX_FIXED) begin
			// nibbles past the word width read as zero
			for (int i = FIXED_HEX_DIGITS - 1; i >= 0; i--) begin
				push_char(digit_chars[(i * 4 < VALUE_BITS) ? int'(raw[i * 4 +: 4]) : 0], i == 0);
				n++;
			end
			return n;
		end
		case (w.command)
			CMD_DEC: radix = 10;
			CMD_OCT: radix = 8;
			default: radix = 16;
		endcase
		mag = w.value;
		if (w.value[VALUE_BITS-1]) begin
			// most negative word wraps to its unsigned magnitude
			mag = -w.value;
			push_char(8'(MINUS_CODE), 1'b0);
			n++;
		end
		cnt = 0;
		do begin
			digs[cnt] = 4'(mag % radix);
			cnt++;
			mag = mag / radix;
		end while (mag != 0 && cnt < DIGITS);
		while (cnt > 0) begin
			cnt--;
			push_char(digit_chars[digs[cnt]], cnt == 0);
			n++;
		end
		return n;
	endfunction

	// cycle count and the long receiver hold-off
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == 1500)
			hold_left <= 400;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
		end else begin
			took = word_valid && !word_stall;
			if (took)
				chars_predicted <= chars_predicted + predict_chars(word);
			if (!word_valid || !word_stall) begin
				if (pending_words.size() != 0
						&& !(pending_words[0].drain && (took || chars_predicted != chars_seen))
						&& (calm || $urandom_range(0, 99) >= 26)) begin
					word       <= pending_words[0].w;
					word_valid <= 1'b1;
					pending_words.pop_front();
				end else begin
					word_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_stall <= 1'b0;
		end else begin
			if (sym_valid && !sym_stall) begin
				chars_seen <= chars_seen + 1;
				if (expected_chars.size() == 0) begin
					error_count += 1;
					if (error_count <= 10)
						$display("unexpected char: char_code %02h last %0b",
							sym.char_code, sym.last);
				end else if (expected_chars[0].char_code != sym.char_code
						|| expected_chars[0].last != sym.last) begin
					error_count += 1;
					if (error_count <= 10)
						$display("mismatch: char_code exp %02h got %02h, last exp %0b got %0b",
							expected_chars[0].char_code, sym.char_code,
							expected_chars[0].last, sym.last);
					void'(expected_chars.pop_front());
				end else begin
					void'(expected_chars.pop_front());
				end
			end
			sym_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < 26);
		end
	end

	task automatic queue_word(input logic [VALUE_BITS-1:0] v, input cmd_t c,
			input bit drain = 1'b0);
		pending_t p;
		p.w.value   = v;
		p.w.command = c;
		p.drain     = drain;
		pending_words.push_back(p);
	endtask

	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] v;
		int                    k;
		k = $urandom_range(0, VALUE_BITS - 1);
		case ($urandom_range(0, 5))
			0: v = VALUE_BITS'($urandom_range(0, 20));
			1: v = -VALUE_BITS'($urandom_range(1, 20));
			2: v = VALUE_BITS'(1) << k;
			3: v = (VALUE_BITS'(1) << k) - 1;
			4: v = -((VALUE_BITS'(1) << k) - 1);
			default: v = VALUE_BITS'($urandom());
		endcase
		return v;
	endfunction

	initial begin
		// extremes in every mode
		for (int c = 0; c < 4; c++) begin
			queue_word('0, cmd_t'(c));
			queue_word('1, cmd_t'(c));
			queue_word({1'b1, {(VALUE_BITS-1){1'b0}}}, cmd_t'(c));
			queue_word({1'b0, {(VALUE_BITS-1){1'b1}}}, cmd_t'(c));
		end
		queue_word(32'd9, CMD_DEC);
		queue_word(32'd10, CMD_DEC);
		queue_word(32'd8, CMD_OCT);
		queue_word(32'h0000_000F, CMD_HEX);
		queue_word(32'h89AB_CDEF, CMD_HEX);
		queue_word(32'h0123_4567, CMD_HEX_FIXED);
		queue_word(32'd1000000000, CMD_DEC, 1'b1);
		for (int i = 0; i < 380; i++)
			queue_word(random_value(), cmd_t'($urandom_range(0, 3)), i == 120 || i == 260);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || word_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/iar_pkg.sv
hdl/iar_digit_reg.sv
hdl/integer_to_ascii_radix_core.sv
tb/testbench.sv
